[design/qau_pkg.sv]
package qau_pkg;

   // default fraction bits of the Q format
   localparam int FRAC_BITS_DEF = 16;

   // exact accumulator width, with room for the rounding half
   localparam int ACC_W     = 68;
   // squared norm, unsigned, up to 2^64
   localparam int NORM_W    = 65;
   // divider partial remainder
   localparam int REM_W     = 66;
   // quotient bits produced, one per divider stage
   localparam int DIV_STEPS = 32;
   localparam int LANES     = 4;

   // component positions
   localparam int CX = 0;
   localparam int CY = 1;
   localparam int CZ = 2;
   localparam int CW = 3;

   // operation codes
   localparam logic [1:0] KIND_PROD = 2'd0;
   localparam logic [1:0] KIND_ROT  = 2'd1;
   localparam logic [1:0] KIND_INV  = 2'd2;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh8000_0000);

   typedef struct packed {
      logic [31:0] val;
      logic        err;
   } rnd_type;

   typedef struct packed {
      logic [LANES-1:0][31:0] val;
      logic                   err;
   } res_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [31:0]      low;
      logic [31:0]      quo;
      logic             ovf;
      logic             neg;
   } div_lane_type;

   // round half up by sh bits, then saturate to 32 bits
   function automatic rnd_type round_sat(input logic signed [ACC_W-1:0] acc, input int sh);
      logic signed [ACC_W-1:0] half;
      logic signed [ACC_W-1:0] sum;
      logic signed [ACC_W-1:0] shf;
      rnd_type                 r;
      half = ACC_W'(1) <<< (sh - 1);
      sum  = acc + half;
      shf  = sum >>> sh;
      if (shf > SAT_HI) begin
         r.val = 32'h7FFF_FFFF;
         r.err = 1'b1;
      end else if (shf < SAT_LO) begin
         r.val = 32'h8000_0000;
         r.err = 1'b1;
      end else begin
         r.val = shf[31:0];
         r.err = 1'b0;
      end
      return r;
   endfunction

   // apply sign and saturate one inverse quotient
   function automatic rnd_type inv_finish(input div_lane_type l);
      rnd_type r;
      if (l.neg) begin
         if (l.ovf || (l.quo > 32'h8000_0000)) begin
            r.val = 32'h8000_0000;
            r.err = 1'b1;
         end else begin
            r.val = 32'd0 - l.quo;
            r.err = 1'b0;
         end
      end else begin
         if (l.ovf || l.quo[31]) begin
            r.val = 32'h7FFF_FFFF;
            r.err = 1'b1;
         end else begin
            r.val = l.quo;
            r.err = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

[design/qau_front.sv]
module qau_front
   import qau_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [1:0]               kind_in,
   input  logic signed [31:0]       a_in [LANES],
   input  logic signed [31:0]       b_in [LANES],
   output res_type                  prod_out,
   output logic signed [31:0]       t_out [3],
   output logic                     t_err_out,
   output logic signed [31:0]       a_out [LANES],
   output logic signed [31:0]       b_out [3],
   output logic [NORM_W-1:0]        norm_out
);

   localparam int NXT1 [3] = '{CY, CZ, CX};
   localparam int NXT2 [3] = '{CZ, CX, CY};

   logic signed [31:0] op_b [LANES];

   logic signed [63:0] p_ff   [LANES][LANES];
   logic signed [31:0] a0_ff  [LANES];
   logic signed [31:0] b0_ff  [3];
   logic signed [64:0] pr1_ff [LANES];
   logic signed [64:0] pr2_ff [LANES];
   logic [63:0]        nrm_ff [2];
   logic signed [31:0] a1_ff  [LANES];
   logic signed [31:0] b1_ff  [3];
   logic signed [65:0] sum_ff [LANES];
   logic signed [31:0] t_ff   [3];
   logic               t_err_ff;
   logic [NORM_W-1:0]  norm_ff;
   logic signed [31:0] a2_ff  [LANES];
   logic signed [31:0] b2_ff  [3];
   res_type            prod_ff;

   // square A for the norm, otherwise multiply by B
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         op_b[j] = (kind_in == KIND_INV) ? a_in[j] : b_in[j];
      end
   end

   // stage 0: all sixteen component products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LANES; i++) begin
            for (int j = 0; j < LANES; j++) begin
               p_ff[i][j] <= a_in[i] * op_b[j];
            end
            a0_ff[i] <= a_in[i];
         end
         for (int k = 0; k < 3; k++) begin
            b0_ff[k] <= b_in[k];
         end
      end
   end

   // stage 1: pair sums; second pair of x, y, z is the cross product
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            pr1_ff[k] <= 65'(p_ff[CW][k]) + 65'(p_ff[k][CW]);
            pr2_ff[k] <= 65'(p_ff[NXT1[k]][NXT2[k]]) - 65'(p_ff[NXT2[k]][NXT1[k]]);
            b1_ff[k]  <= b0_ff[k];
         end
         pr1_ff[CW] <= 65'(p_ff[CW][CW]) - 65'(p_ff[CX][CX]);
         pr2_ff[CW] <= -65'(p_ff[CY][CY]) - 65'(p_ff[CZ][CZ]);
         nrm_ff[0]  <= $unsigned(p_ff[CW][CW]) + $unsigned(p_ff[CX][CX]);
         nrm_ff[1]  <= $unsigned(p_ff[CY][CY]) + $unsigned(p_ff[CZ][CZ]);
         a1_ff      <= a0_ff;
      end
   end

   // stage 2: product sums, rotation term t, squared norm
   always_ff @(posedge clock) begin
      rnd_type tr;
      logic    terr;
      if (en) begin
         terr = 1'b0;
         for (int k = 0; k < LANES; k++) begin
            sum_ff[k] <= 66'(pr1_ff[k]) + 66'(pr2_ff[k]);
         end
         for (int k = 0; k < 3; k++) begin
            tr       = round_sat(ACC_W'(pr2_ff[k]), FRAC_BITS - 1);
            t_ff[k] <= tr.val;
            terr     = terr | tr.err;
            b2_ff[k] <= b1_ff[k];
         end
         t_err_ff <= terr;
         norm_ff  <= NORM_W'(nrm_ff[0]) + NORM_W'(nrm_ff[1]);
         a2_ff    <= a1_ff;
      end
   end

   // stage 3: round and saturate the product
   always_ff @(posedge clock) begin
      rnd_type pr;
      logic    perr;
      if (en) begin
         perr = 1'b0;
         for (int k = 0; k < LANES; k++) begin
            pr              = round_sat(ACC_W'(sum_ff[k]), FRAC_BITS);
            prod_ff.val[k] <= pr.val;
            perr            = perr | pr.err;
         end
         prod_ff.err <= perr;
      end
   end

   assign prod_out  = prod_ff;
   assign t_out     = t_ff;
   assign t_err_out = t_err_ff;
   assign a_out     = a2_ff;
   assign b_out     = b2_ff;
   assign norm_out  = norm_ff;

endmodule

[design/qau_rotate.sv]
module qau_rotate
   import qau_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] t_in [3],
   input  logic               t_err_in,
   input  logic signed [31:0] a_in [LANES],
   input  logic signed [31:0] b_in [3],
   output res_type            rot_out
);

   localparam int NXT1 [3] = '{CY, CZ, CX};
   localparam int NXT2 [3] = '{CZ, CX, CY};

   logic signed [63:0] mw_ff [3];
   logic signed [63:0] mp_ff [3];
   logic signed [63:0] mn_ff [3];
   logic signed [63:0] bs_ff [3];
   logic               e3_ff;
   logic signed [64:0] s1_ff [3];
   logic signed [64:0] s2_ff [3];
   logic               e4_ff;
   logic signed [65:0] sum_ff [3];
   logic               e5_ff;
   res_type            rot_ff;

   // stage 3: w*t, q x t terms, v scaled up
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            mw_ff[k] <= t_in[k] * a_in[CW];
            mp_ff[k] <= a_in[NXT1[k]] * t_in[NXT2[k]];
            mn_ff[k] <= a_in[NXT2[k]] * t_in[NXT1[k]];
            bs_ff[k] <= 64'(b_in[k]) <<< FRAC_BITS;
         end
         e3_ff <= t_err_in;
      end
   end

   // stage 4: pair sums
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            s1_ff[k] <= 65'(bs_ff[k]) + 65'(mw_ff[k]);
            s2_ff[k] <= 65'(mp_ff[k]) - 65'(mn_ff[k]);
         end
         e4_ff <= e3_ff;
      end
   end

   // stage 5: full sums
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            sum_ff[k] <= 66'(s1_ff[k]) + 66'(s2_ff[k]);
         end
         e5_ff <= e4_ff;
      end
   end

   // stage 6: round and saturate; scalar part is zero
   always_ff @(posedge clock) begin
      rnd_type rr;
      logic    rerr;
      if (en) begin
         rerr = e5_ff;
         for (int k = 0; k < 3; k++) begin
            rr             = round_sat(ACC_W'(sum_ff[k]), FRAC_BITS);
            rot_ff.val[k] <= rr.val;
            rerr           = rerr | rr.err;
         end
         rot_ff.val[CW] <= 32'd0;
         rot_ff.err     <= rerr;
      end
   end

   assign rot_out = rot_ff;

endmodule

[design/qau_divider.sv]
module qau_divider
   import qau_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] a_in [LANES],
   input  logic [NORM_W-1:0]  norm_in,
   output div_lane_type       lane_out [LANES],
   output logic               zero_out
);

   localparam int NUM_W = 32 + 2 * FRAC_BITS;

   div_lane_type      lane_ff [DIV_STEPS+1][LANES];
   logic [NORM_W-1:0] norm_ff [DIV_STEPS+1];
   logic              zero_ff [DIV_STEPS+1];

   // prep stage: magnitude, top remainder, overflow check, sign
   always_ff @(posedge clock) begin
      logic [31:0]      mag;
      logic [NUM_W-1:0] num;
      logic [REM_W-1:0] rem0;
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            mag  = a_in[l][31] ? 32'd0 - 32'(a_in[l]) : 32'(a_in[l]);
            num  = {mag, {(2 * FRAC_BITS){1'b0}}};
            rem0 = REM_W'(num[NUM_W-1:32]);
            lane_ff[0][l].rem <= rem0;
            lane_ff[0][l].low <= num[31:0];
            lane_ff[0][l].quo <= 32'd0;
            lane_ff[0][l].ovf <= (rem0 >= REM_W'(norm_in));
            if (l == CW) begin
               lane_ff[0][l].neg <= a_in[l][31];
            end else begin
               lane_ff[0][l].neg <= !a_in[l][31] && (a_in[l] != 32'sd0);
            end
         end
         norm_ff[0] <= norm_in;
         zero_ff[0] <= (norm_in == '0);
      end
   end

   // one quotient bit per stage, restoring division
   for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
      always_ff @(posedge clock) begin
         logic [REM_W-1:0] rsh;
         logic [REM_W-1:0] den;
         if (en) begin
            den = REM_W'(norm_ff[s-1]);
            for (int l = 0; l < LANES; l++) begin
               rsh = {lane_ff[s-1][l].rem[REM_W-2:0], lane_ff[s-1][l].low[31]};
               lane_ff[s][l].low <= {lane_ff[s-1][l].low[30:0], 1'b0};
               lane_ff[s][l].ovf <= lane_ff[s-1][l].ovf;
               lane_ff[s][l].neg <= lane_ff[s-1][l].neg;
               if (rsh >= den) begin
                  lane_ff[s][l].rem <= rsh - den;
                  lane_ff[s][l].quo <= {lane_ff[s-1][l].quo[30:0], 1'b1};
               end else begin
                  lane_ff[s][l].rem <= rsh;
                  lane_ff[s][l].quo <= {lane_ff[s-1][l].quo[30:0], 1'b0};
               end
            end
            norm_ff[s] <= norm_ff[s-1];
            zero_ff[s] <= zero_ff[s-1];
         end
      end
   end

   assign lane_out = lane_ff[DIV_STEPS];
   assign zero_out = zero_ff[DIV_STEPS];

endmodule

[design/quaternion_arithmetic_unit.sv]
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tdata a_x..a_w, b_x..b_w; tuser kind
// rsp_      out        rsp_tvalid/rsp_tready  tdata r_x..r_w; tuser error
//
// One word enters per cycle while the skid entry is empty; the depth from accept to the
// result register is set by the 32-stage inverse divider (one quotient bit a stage).
// Every operation runs through the same depth, so results keep input order.
// Synchronous active-high reset clears the pipeline valid bits and the output-side valid flags.
// A two-word output buffer freezes the pipeline only once both entries are full.
module quaternion_arithmetic_unit
   import qau_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [255:0] req_tdata,  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
   input  logic [1:0]   req_tuser,  // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // r_x, r_y, r_z, r_w
   output logic         rsp_tuser   // error
);

   localparam int PROD_ST = 3;
   localparam int ROT_ST  = 6;
   localparam int LAST    = 3 + DIV_STEPS;

   logic               en;
   logic [LAST:0]      v_ff;
   logic [1:0]         kind_ff [LAST+1];
   logic signed [31:0] a_in [LANES];
   logic signed [31:0] b_in [LANES];

   res_type            prod_s3;
   res_type            rot_s6;
   logic signed [31:0] t_s2 [3];
   logic               t_err_s2;
   logic signed [31:0] a_s2 [LANES];
   logic signed [31:0] b_s2 [3];
   logic [NORM_W-1:0]  norm_s2;
   div_lane_type       div_lanes [LANES];
   logic               div_zero;

   res_type            prod_dl_ff [PROD_ST+1:LAST];
   res_type            rot_dl_ff  [ROT_ST+1:LAST];

   res_type            fin;
   res_type            out_ff;
   res_type            skid_ff;
   logic               out_v_ff;
   logic               skid_v_ff;
   logic               push;
   logic               pop;

   // unpack the request word
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         a_in[i] = req_tdata[32*i +: 32];
         b_in[i] = req_tdata[128 + 32*i +: 32];
      end
   end

   // advance the whole pipeline unless the skid entry is occupied
   assign en         = !skid_v_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAST-1:0], req_tvalid};
      end
   end

   // carry the operation code along the stages
   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff[0] <= req_tuser;
         for (int s = 1; s <= LAST; s++) begin
            kind_ff[s] <= kind_ff[s-1];
         end
      end
   end

   qau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .en        (en),
      .kind_in   (req_tuser),
      .a_in      (a_in),
      .b_in      (b_in),
      .prod_out  (prod_s3),
      .t_out     (t_s2),
      .t_err_out (t_err_s2),
      .a_out     (a_s2),
      .b_out     (b_s2),
      .norm_out  (norm_s2)
   );

   qau_rotate #(.FRAC_BITS(FRAC_BITS)) u_rotate (
      .clock    (clock),
      .en       (en),
      .t_in     (t_s2),
      .t_err_in (t_err_s2),
      .a_in     (a_s2),
      .b_in     (b_s2),
      .rot_out  (rot_s6)
   );

   qau_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
      .clock    (clock),
      .en       (en),
      .a_in     (a_s2),
      .norm_in  (norm_s2),
      .lane_out (div_lanes),
      .zero_out (div_zero)
   );

   // delay the short paths to the divider's depth
   always_ff @(posedge clock) begin
      if (en) begin
         prod_dl_ff[PROD_ST+1] <= prod_s3;
         for (int s = PROD_ST + 2; s <= LAST; s++) begin
            prod_dl_ff[s] <= prod_dl_ff[s-1];
         end
         rot_dl_ff[ROT_ST+1] <= rot_s6;
         for (int s = ROT_ST + 2; s <= LAST; s++) begin
            rot_dl_ff[s] <= rot_dl_ff[s-1];
         end
      end
   end

   // select the result of the operation
   always_comb begin
      rnd_type ir;
      fin = '0;
      case (kind_ff[LAST])
         KIND_PROD: fin = prod_dl_ff[LAST];
         KIND_ROT:  fin = rot_dl_ff[LAST];
         KIND_INV: begin
            if (div_zero) begin
               fin.err = 1'b1;
            end else begin
               for (int l = 0; l < LANES; l++) begin
                  ir          = inv_finish(div_lanes[l]);
                  fin.val[l]  = ir.val;
                  fin.err     = fin.err | ir.err;
               end
            end
         end
         default: fin.err = 1'b1;
      endcase
   end

   // output register with one skid entry
   assign push = en && v_ff[LAST];
   assign pop  = out_v_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) begin
            skid_v_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_v_ff && !pop) begin
            skid_v_ff <= 1'b1;
         end else begin
            out_v_ff <= 1'b1;
         end
      end else if (pop) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_v_ff && !pop) begin
            skid_ff <= fin;
         end else begin
            out_ff <= fin;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff.val;
   assign rsp_tuser  = out_ff.err;

   // skid entry is never used while the output register is empty
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid holds a word while output register is empty");

   // a word leaving the pipeline onto a blocked output lands in the skid
   a_skid_catch: assert property (@(posedge clock) disable iff (reset)
      (push && out_v_ff && !rsp_tready) |=> skid_v_ff)
      else $error("word lost on blocked output");

   // pipeline valid bits hold while frozen
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v_ff))
      else $error("pipeline moved while frozen");

   // skid fills only while the receiver was not ready to take the output
   a_skid_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(!rsp_tready))
      else $error("skid filled while output was taken");

endmodule

[tb/tb.sv]
module tb;
   import qau_pkg::*;

   localparam int FB       = 16;
   localparam int N_RANDOM = 1400;
   localparam int IDLE_MAX = 20000;
   localparam int DRAIN    = 80;

   typedef struct {
      logic [1:0]         kind;
      logic signed [31:0] a [4];
      logic signed [31:0] b [4];
   } quat_op_type;

   typedef struct {
      logic [31:0] r [4];
      logic        err;
   } quat_res_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [255:0] req_tdata = '0;  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
   logic [1:0]   req_tuser = '0;  // kind
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;       // r_x, r_y, r_z, r_w
   logic         rsp_tuser;       // error

   quat_res_type pending_results[$];
   int           n_fail = 0;
   int           idle_cycles = 0;

   quaternion_arithmetic_unit i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // round half up from sh fraction bits, saturate to 32 bits
   function automatic logic [31:0] rnd_sat(input logic signed [127:0] v, input int sh,
                                           inout logic err);
      logic signed [127:0] s;
      s = (v + (128'sd1 <<< (sh - 1))) >>> sh;
      if (s > 128'sh7FFF_FFFF) begin
         err = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (s < -128'sh8000_0000) begin
         err = 1'b1;
         return 32'h8000_0000;
      end
      return s[31:0];
   endfunction

   // truncating quotient of c * 2^(2F) by the norm, sign applied, saturated
   function automatic logic [31:0] inv_lane(input logic signed [31:0] c, input bit neg,
                                            input logic [127:0] norm, inout logic err);
      logic [127:0] mag, q;
      mag = (c < 0) ? 128'(-64'(c)) : 128'(c);
      q   = (mag << (2 * FB)) / norm;
      if (q == 0) return 32'd0;
      if (neg) begin
         if (q > 128'h8000_0000) begin
            err = 1'b1;
            return 32'h8000_0000;
         end
         return 32'd0 - q[31:0];
      end
      if (q > 128'h7FFF_FFFF) begin
         err = 1'b1;
         return 32'h7FFF_FFFF;
      end
      return q[31:0];
   endfunction

   function automatic quat_res_type quat_compute(input quat_op_type op);
      quat_res_type        res;
      logic signed [127:0] ax, ay, az, aw, bx, by, bz, bw, tx, ty, tz, acc;
      logic [127:0]        norm;
      ax = op.a[CX]; ay = op.a[CY]; az = op.a[CZ]; aw = op.a[CW];
      bx = op.b[CX]; by = op.b[CY]; bz = op.b[CZ]; bw = op.b[CW];
      res.err = 1'b0;
      res.r   = '{default: 32'd0};
      case (op.kind)
         KIND_PROD: begin
            res.r[CX] = rnd_sat(aw*bx + ax*bw + ay*bz - az*by, FB, res.err);
            res.r[CY] = rnd_sat(aw*by + ay*bw + az*bx - ax*bz, FB, res.err);
            res.r[CZ] = rnd_sat(aw*bz + az*bw + ax*by - ay*bx, FB, res.err);
            res.r[CW] = rnd_sat(aw*bw - ax*bx - ay*by - az*bz, FB, res.err);
         end
         KIND_ROT: begin
            // t = 2 (q x v) held at 32 bits
            tx = $signed(rnd_sat(ay*bz - az*by, FB - 1, res.err));
            ty = $signed(rnd_sat(az*bx - ax*bz, FB - 1, res.err));
            tz = $signed(rnd_sat(ax*by - ay*bx, FB - 1, res.err));
            acc = (bx <<< FB) + tx*aw + ay*tz - az*ty;
            res.r[CX] = rnd_sat(acc, FB, res.err);
            acc = (by <<< FB) + ty*aw + az*tx - ax*tz;
            res.r[CY] = rnd_sat(acc, FB, res.err);
            acc = (bz <<< FB) + tz*aw + ax*ty - ay*tx;
            res.r[CZ] = rnd_sat(acc, FB, res.err);
         end
         KIND_INV: begin
            norm = aw*aw + ax*ax + ay*ay + az*az;
            if (norm == 0) res.err = 1'b1;
            else begin
               res.r[CX] = inv_lane(op.a[CX], op.a[CX] > 0, norm, res.err);
               res.r[CY] = inv_lane(op.a[CY], op.a[CY] > 0, norm, res.err);
               res.r[CZ] = inv_lane(op.a[CZ], op.a[CZ] > 0, norm, res.err);
               res.r[CW] = inv_lane(op.a[CW], op.a[CW] < 0, norm, res.err);
            end
         end
         default: res.err = 1'b1;
      endcase
      return res;
   endfunction

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'd0;
         3: return 32'($signed($urandom_range(8)) - 4) <<< FB;
         4, 5: return $urandom;
         default: return 32'($signed($urandom_range(262143)) - 131072);
      endcase
   endfunction

   task automatic send_op(input quat_op_type op);
      int gap;
      gap = ($urandom_range(9) == 0) ? $urandom_range(40) :
            ($urandom_range(2) == 0 ? $urandom_range(2) : 0);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op.kind;
      req_tdata  <= {op.b[CW], op.b[CZ], op.b[CY], op.b[CX],
                     op.a[CW], op.a[CZ], op.a[CY], op.a[CX]};
      pending_results.push_back(quat_compute(op));
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
      if (exp !== act) begin
         $error("%s expected %h actual %h", name, exp, act);
         n_fail++;
      end
   endtask

   // receiver stalls
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if ($urandom_range(49) == 0) rsp_tready <= 1'b0;
      else if (!rsp_tready) rsp_tready <= ($urandom_range(3) == 0);
      else rsp_tready <= ($urandom_range(5) != 0);
   end

   // compare each result word with the oldest pending one
   always @(posedge clock) begin
      quat_res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result word %h", rsp_tdata);
            n_fail++;
         end else begin
            want = pending_results.pop_front();
            check_field("r_x", want.r[CX], rsp_tdata[31:0]);
            check_field("r_y", want.r[CY], rsp_tdata[63:32]);
            check_field("r_z", want.r[CZ], rsp_tdata[95:64]);
            check_field("r_w", want.r[CW], rsp_tdata[127:96]);
            check_field("error", 32'(want.err), 32'(rsp_tuser));
         end
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else if (!reset) idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_MAX) begin
         $display("simulation failed");
         $finish;
      end
   end

   // directed rows: kind, a (x,y,z,w), b (x,y,z,w), typed result where obvious
   localparam int N_DIR = 16;
   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
   localparam logic [31:0] MAXN = 32'h8000_0000;

   initial begin
      quat_op_type  op;
      quat_res_type exp_typed;
      logic [31:0] rows [N_DIR][8];
      logic [1:0]  kinds [N_DIR];
      bit          typed [N_DIR];
      rows = '{
         '{0, 0, 0, ONE, 0, 0, 0, ONE},           // identity * identity
         '{0, 0, 0, 0, 0, 0, 0, 0},               // zero norm inverse
         '{0, 0, 0, 0, 1, 2, 3, 4},               // undefined kind
         '{MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP},
         '{MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, MAXN},
         '{MAXN, MAXP, MAXN, MAXP, MAXP, MAXN, MAXP, MAXN},
         '{ONE, 0, 0, 0, 0, ONE, 0, 0},
         '{0, 0, ONE, 0, ONE, 0, 0, 0},           // rotate about z
         '{MAXP, MAXN, MAXP, MAXN, MAXP, MAXN, MAXP, MAXN},
         '{1, 0, 0, 0, 0, 0, 0, 0},               // tiny norm, saturating inverse
         '{0, 0, 0, MAXN, 0, 0, 0, 0},
         '{0, 0, 0, 32'hFFFF_0000, 0, 0, 0, 0},
         '{32'h8000, 32'h8000, 32'h8000, 32'h8000, 1, 1, 1, 1},
         '{0, 0, 0, 32'hFFFF_FFFF, 32'h0000_8000, 0, 0, 0},  // rounding tie
         '{MAXP, MAXP, MAXP, MAXP, 0, 0, 0, 0},
         '{32'h0001_8000, 32'hFFFE_8000, 3, 32'h0002_0000, 5, 6, 7, 8}
      };
      kinds = '{KIND_PROD, KIND_INV, 2'd3, KIND_PROD, KIND_PROD, KIND_ROT, KIND_PROD,
                KIND_ROT, KIND_ROT, KIND_INV, KIND_INV, KIND_INV, KIND_ROT, KIND_PROD,
                KIND_INV, KIND_ROT};
      typed = '{1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIR; i++) begin
         op.kind = kinds[i];
         for (int c = 0; c < 4; c++) begin
            op.a[c] = rows[i][c];
            op.b[c] = rows[i][4 + c];
         end
         send_op(op);
         // rows whose answer is plain override the predicted one
         if (typed[i]) begin
            exp_typed.r   = '{default: 32'd0};
            exp_typed.err = (kinds[i] != KIND_PROD);
            if (kinds[i] == KIND_PROD) exp_typed.r[CW] = ONE;
            pending_results[pending_results.size() - 1] = exp_typed;
         end
      end
      req_tvalid <= 1'b0;

      // hold off until the pipeline has drained
      while (pending_results.size() != 0) @(posedge clock);
      @(posedge clock);

      for (int n = 0; n < N_RANDOM; n++) begin
         op.kind = ($urandom_range(29) == 0) ? 2'd3 : 2'($urandom_range(2));
         for (int c = 0; c < 4; c++) begin
            op.a[c] = rand_comp();
            op.b[c] = rand_comp();
         end
         send_op(op);
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (n_fail == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

[quaternion_arithmetic_unit.f]
design/qau_pkg.sv
design/qau_front.sv
design/qau_rotate.sv
design/qau_divider.sv
design/quaternion_arithmetic_unit.sv
tb/tb.sv
